// ===== rtl/core/gts_pkg.sv =====
// Shared types and constants of the gain and tanh saturator.
// Depends on nothing; imported by gts_tanh_lookup and gain_tanh_saturator.
`default_nettype none

package gts_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Register widths.
    localparam int GAIN_W = 14;
    localparam int SAT_W  = 13;

    // Q12 rounding constants for the gain and drive products.
    localparam int Q12_SHIFT = 12;
    localparam int Q12_HALF  = 2048;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);
    localparam logic [SAT_W-1:0]  SAT_RESET  = SAT_W'(2048);

    // Q30 one, used while the tanh table is built.
    localparam longint ONE_Q30 = longint'(1) <<< 30;

    // Register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_LINEAR       = CFG_INDEX_W'(0),
        REG_SATURATION_AMOUNT = CFG_INDEX_W'(1)
    } t_cfg_reg;

    // Control that travels with a sample into the tanh back end.
    typedef struct packed {
        logic byp;   // saturation amount is zero, pass the gained sample
        logic clip;  // the bypass value was saturated
        logic neg;   // overdrive value is negative
        logic big;   // overdrive magnitude is at or above eight
    } t_tctl;

    // Unsigned restoring division, one quotient bit per step.
    // Only used while constant tables are built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gts_tanh_lookup.sv =====
// Tanh back end: table index, registered table read, linear interpolation,
// sign and output select. Depends on gts_pkg.
`default_nettype none

module gts_tanh_lookup
    import gts_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [SAMPLE_BITS+1:0]        i_mag,
    input  wire t_tctl                         i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_byp_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_clipped
);

    localparam int FB     = SAMPLE_BITS - 1;
    localparam int MW     = SAMPLE_BITS + 2;
    localparam int AW     = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PW     = FB + MW + 2;
    localparam int NSTAGE = 6;

    localparam longint FULL_POS = (longint'(1) <<< FB) - 1;
    localparam logic [MW+AW-1:0] DEPTH_K = (MW + AW)'(TANH_TABLE_DEPTH);
    localparam logic [PW-1:0]    INT_HALF = PW'(1) << (MW - 1);

    typedef logic [FB-1:0] t_rom [0:TANH_TABLE_DEPTH];

    // Table of round(tanh(8*i/D) * 2^FB), built in Q30 with exp(-16/D)
    // from a Taylor series and its powers by repeated multiplication.
    function automatic t_rom build_rom();
        t_rom   rom;
        longint t;
        longint term;
        longint r;
        longint e;
        longint den;
        longint num;
        longint v;
        t    = ((longint'(16) <<< 30) + TANH_TABLE_DEPTH / 2) / TANH_TABLE_DEPTH;
        term = ONE_Q30;
        r    = ONE_Q30;
        e    = ONE_Q30;
        for (int k = 1; k <= 14; k++) begin
            term = longint'(udiv64(64'(term * t + longint'(k) * (ONE_Q30 / 2)),
                                   64'(longint'(k) * ONE_Q30)));
            r = ((k % 2) == 1) ? r - term : r + term;
        end
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            den    = 2 * (ONE_Q30 + e);
            num    = (ONE_Q30 - e) * (longint'(1) <<< SAMPLE_BITS) + (ONE_Q30 + e);
            v      = longint'(udiv64(64'(num), 64'(den)));
            rom[i] = (v > FULL_POS) ? FB'(FULL_POS) : FB'(v);
            e      = (e * r + (ONE_Q30 / 2)) >>> 30;
        end
        return rom;
    endfunction

    localparam t_rom TANH_ROM = build_rom();

    // Stage valid bits and per-stage advance enables.
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_en;

    // Stage payload.
    logic [AW-1:0]                r_s1_idx;
    logic [MW-1:0]                r_s1_frac;
    t_tctl                        r_s1_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s1_y;
    logic [FB-1:0]                r_s2_lo;
    logic [FB-1:0]                r_s2_hi;
    logic [MW-1:0]                r_s2_frac;
    t_tctl                        r_s2_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s2_y;
    logic signed [FB:0]           r_s3_diff;
    logic [FB-1:0]                r_s3_lo;
    logic [MW-1:0]                r_s3_frac;
    t_tctl                        r_s3_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s3_y;
    logic signed [PW-1:0]         r_s4_prod;
    logic [FB-1:0]                r_s4_lo;
    t_tctl                        r_s4_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s4_y;
    logic [FB-1:0]                r_s5_mag;
    t_tctl                        r_s5_ctl;
    logic signed [SAMPLE_BITS-1:0] r_s5_y;
    logic signed [SAMPLE_BITS-1:0] r_out_y;
    logic                         r_out_clip;

    logic [MW+AW-1:0]     n_p;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] n_rsum;
    logic signed [FB+2:0] n_res;
    logic [SAMPLE_BITS-1:0] n_ext;

    // A stage advances when it is empty or the next one advances.
    always_comb begin
        n_en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign o_ready      = n_en[0];
    assign o_valid      = r_vld[NSTAGE-1];
    assign o_sample_out = r_out_y;
    assign o_clipped    = r_out_clip;

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Datapath arithmetic between the stage registers.
    assign n_p    = (MW + AW)'(i_mag) * DEPTH_K;
    assign n_prod = r_s3_diff * $signed({1'b0, r_s3_frac});
    assign n_rsum = r_s4_prod + $signed(INT_HALF);
    assign n_res  = $signed({3'b000, r_s4_lo}) + $signed({n_rsum[PW-1], n_rsum[PW-1:MW]});
    assign n_ext  = {1'b0, r_s5_mag};

    // Stage 1: scale the magnitude by the table depth, split index and fraction.
    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_s1_idx  <= n_p[MW+AW-1:MW];
            r_s1_frac <= n_p[MW-1:0];
            r_s1_ctl  <= i_ctl;
            r_s1_y    <= i_byp_y;
        end
    end

    // Stage 2: registered read of both neighboring table points.
    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_s2_lo   <= TANH_ROM[r_s1_idx];
            r_s2_hi   <= TANH_ROM[r_s1_idx + AW'(1)];
            r_s2_frac <= r_s1_frac;
            r_s2_ctl  <= r_s1_ctl;
            r_s2_y    <= r_s1_y;
        end
    end

    // Stage 3: slope between the two points.
    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r_s3_diff <= $signed({1'b0, r_s2_hi}) - $signed({1'b0, r_s2_lo});
            r_s3_lo   <= r_s2_lo;
            r_s3_frac <= r_s2_frac;
            r_s3_ctl  <= r_s2_ctl;
            r_s3_y    <= r_s2_y;
        end
    end

    // Stage 4: slope times fraction.
    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            r_s4_prod <= n_prod;
            r_s4_lo   <= r_s3_lo;
            r_s4_ctl  <= r_s3_ctl;
            r_s4_y    <= r_s3_y;
        end
    end

    // Stage 5: round the interpolation, add the base point, cap at full scale.
    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            if (r_s4_ctl.big || (n_res > $signed((FB + 3)'(FULL_POS)))) begin
                r_s5_mag <= FB'(FULL_POS);
            end else begin
                r_s5_mag <= n_res[FB-1:0];
            end
            r_s5_ctl <= r_s4_ctl;
            r_s5_y   <= r_s4_y;
        end
    end

    // Stage 6: output register, sign applied or bypass value selected.
    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            if (r_s5_ctl.byp) begin
                r_out_y    <= r_s5_y;
                r_out_clip <= r_s5_ctl.clip;
            end else begin
                r_out_y    <= r_s5_ctl.neg ? $signed(~n_ext + 1'b1) : $signed(n_ext);
                r_out_clip <= 1'b0;
            end
        end
    end

    // A large drive always lands on full scale.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && r_s5_ctl.big) |-> (r_s5_mag == FB'(FULL_POS)))
        else $error("tanh: large drive did not reach full scale");

    // An empty first stage always takes an item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("tanh: empty entry stage refused an item");

    // The shaping path never flags clipping.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !r_s5_ctl.byp && n_en[5]) |=> !o_clipped)
        else $error("tanh: shaping path raised clipped");

endmodule

`default_nettype wire

// ===== rtl/core/gain_tanh_saturator.sv =====
// Gain stage with optional tanh soft clipper: top level, configuration
// registers and front-end pipeline. Depends on gts_pkg and gts_tanh_lookup.
//
// Takes one signed sample per cycle and delivers one result per item after
// thirteen register stages (seven in the gain and drive front end, six in the
// tanh back end), so with a ready consumer the throughput is one item per
// clock. Each stage holds at most one multiplier; the table read is registered.
// A stall at the output only holds the stages that are full, empty stages
// behind them keep filling, and the result register lets a new item enter
// while a finished one waits. Registers are written through a separate port
// that is always ready; write them only while no item is in flight.
`default_nettype none

module gain_tanh_saturator
    import gts_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_clipped,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int FB     = SAMPLE_BITS - 1;
    localparam int NSTAGE = 7;

    localparam logic signed [SB+2:0]  G_MAX = (SB + 3)'((longint'(1) <<< FB) - 1);
    localparam logic signed [SB+2:0]  G_MIN = (SB + 3)'(-(longint'(1) <<< FB));
    localparam logic [2*SB+5:0]       SQ_HALF = (2 * SB + 6)'(1) << (FB - 1);

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_linear;
    logic [SAT_W-1:0]  r_saturation_amount;

    // Stage valid bits and advance enables.
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_en;
    logic              n_t_ready;

    // Stage payload.
    logic signed [SB+14:0]  r_s1_prod;
    logic signed [SB+2:0]   r_s2_g;
    logic [2*SB+5:0]        r_s3_sq;
    logic signed [SB+2:0]   r_s3_g;
    logic signed [SB-1:0]   r_s3_y;
    logic                   r_s3_clip;
    logic [SB+6:0]          r_s4_g2;
    logic signed [SB+2:0]   r_s4_g;
    logic signed [SB-1:0]   r_s4_y;
    logic                   r_s4_clip;
    logic [SB+19:0]         r_s5_sg;
    logic signed [SB+2:0]   r_s5_g;
    logic signed [SB-1:0]   r_s5_y;
    logic                   r_s5_clip;
    logic signed [SB+8:0]   r_s6_od;
    logic signed [SB-1:0]   r_s6_y;
    logic                   r_s6_clip;
    logic [SB+1:0]          r_s7_mag;
    t_tctl                  r_s7_ctl;
    logic signed [SB-1:0]   r_s7_y;

    logic signed [SB+14:0]  n_prod;
    logic signed [SB+14:0]  n_gsum;
    logic signed [2*SB+5:0] n_sq;
    logic [2*SB+5:0]        n_sqsum;
    logic [SB+19:0]         n_sg;
    logic [SB+19:0]         n_sgsum;
    logic [SB+8:0]          n_od_abs;

    // Configuration writes; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_linear       <= GAIN_RESET;
            r_saturation_amount <= SAT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_LINEAR:       r_gain_linear       <= i_cfg_data[GAIN_W-1:0];
                REG_SATURATION_AMOUNT: r_saturation_amount <= i_cfg_data[SAT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the next one advances.
    always_comb begin
        n_en[NSTAGE-1] = !r_vld[NSTAGE-1] || n_t_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign o_ready = n_en[0];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Arithmetic between the stage registers.
    assign n_prod   = i_sample_in * $signed({1'b0, r_gain_linear});
    assign n_gsum   = r_s1_prod + (SB + 15)'(Q12_HALF);
    assign n_sq     = r_s2_g * r_s2_g;
    assign n_sqsum  = r_s3_sq + SQ_HALF;
    assign n_sg     = r_saturation_amount * r_s4_g2;
    assign n_sgsum  = r_s5_sg + (SB + 20)'(Q12_HALF);
    assign n_od_abs = r_s6_od[SB+8] ? (~r_s6_od + 1'b1) : r_s6_od;

    // Stage 1: sample times linear gain.
    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_s1_prod <= n_prod;
        end
    end

    // Stage 2: round the gained sample back to the sample format.
    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_s2_g <= n_gsum[SB+14:Q12_SHIFT];
        end
    end

    // Stage 3: square for the drive term, saturated value for the bypass.
    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r_s3_sq <= n_sq;
            r_s3_g  <= r_s2_g;
            if (r_s2_g > G_MAX) begin
                r_s3_y    <= G_MAX[SB-1:0];
                r_s3_clip <= 1'b1;
            end else if (r_s2_g < G_MIN) begin
                r_s3_y    <= G_MIN[SB-1:0];
                r_s3_clip <= 1'b1;
            end else begin
                r_s3_y    <= r_s2_g[SB-1:0];
                r_s3_clip <= 1'b0;
            end
        end
    end

    // Stage 4: round the square back to the sample format.
    always_ff @(posedge i_clk) begin
        if (n_en[3]) begin
            r_s4_g2   <= n_sqsum[2*SB+5:FB];
            r_s4_g    <= r_s3_g;
            r_s4_y    <= r_s3_y;
            r_s4_clip <= r_s3_clip;
        end
    end

    // Stage 5: weight the square by the saturation amount.
    always_ff @(posedge i_clk) begin
        if (n_en[4]) begin
            r_s5_sg   <= n_sg;
            r_s5_g    <= r_s4_g;
            r_s5_y    <= r_s4_y;
            r_s5_clip <= r_s4_clip;
        end
    end

    // Stage 6: overdrive value, gained sample minus the rounded drive term.
    always_ff @(posedge i_clk) begin
        if (n_en[5]) begin
            r_s6_od   <= {{6{r_s5_g[SB+2]}}, r_s5_g} - {1'b0, n_sgsum[SB+19:Q12_SHIFT]};
            r_s6_y    <= r_s5_y;
            r_s6_clip <= r_s5_clip;
        end
    end

    // Stage 7: magnitude, sign, range and bypass flags for the tanh back end.
    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            r_s7_mag      <= n_od_abs[SB+1:0];
            r_s7_ctl.neg  <= r_s6_od[SB+8];
            r_s7_ctl.big  <= |n_od_abs[SB+8:SB+2];
            r_s7_ctl.byp  <= (r_saturation_amount == '0);
            r_s7_ctl.clip <= r_s6_clip;
            r_s7_y        <= r_s6_y;
        end
    end

    // Tanh lookup, interpolation and output register.
    gts_tanh_lookup #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_tanh (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_vld[NSTAGE-1]),
        .o_ready      (n_t_ready),
        .i_mag        (r_s7_mag),
        .i_ctl        (r_s7_ctl),
        .i_byp_y      (r_s7_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

    // An accepted item occupies the first stage in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("front end: accepted item was lost");

    // A clipped result sits at one of the two extremes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            ((o_sample_out == G_MAX[SB-1:0]) || (o_sample_out == G_MIN[SB-1:0])))
        else $error("front end: clipped result is not at full scale");

    // An empty entry stage always takes an item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("front end: empty entry stage refused an item");

endmodule

`default_nettype wire
